// ===== hw/rtl/strmm_pkg.sv =====
// ----------------------------------------------------------------------------
// strmm_pkg
// Shared types and codes of the sparse-table range max / min engine.
// ----------------------------------------------------------------------------
package strmm_pkg;

   // fixed field widths
   localparam int VAL_W = 31;
   localparam int IDX_W = 10;
   localparam int LEN_W = IDX_W + 1;
   localparam int LOG_W = $clog2(LEN_W);

   // default sizing
   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_LEVELS       = 11;

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_RANGE = 2'd1;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [VAL_W-1:0] upper_value;
      logic [VAL_W-1:0] lower_value;
      logic [IDX_W-1:0] range_left;
      logic [IDX_W-1:0] range_right;
   } req_payload_type;

   typedef struct packed {
      logic [VAL_W-1:0] range_max;
      logic [VAL_W-1:0] range_min;
      logic [1:0]       status;
   } rsp_payload_type;

   // one stored entry: running max of upper values, running min of lower values
   typedef struct packed {
      logic [VAL_W-1:0] upper;
      logic [VAL_W-1:0] lower;
   } pair_type;

endpackage

// ===== hw/rtl/strmm_chan_if.sv =====
// ----------------------------------------------------------------------------
// strmm_chan_if
// Valid / ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface strmm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sparse_table_range_min_max_core.sv =====
// Query path: the table read registers and status stage, then the result register.
// Throughput: one load or query per cycle while the result register drains;
// a build holds off requests until the table is filled, one table entry per
// cycle through the single table memory.
// Reset: synchronous; clears count, built flag and pipeline; table memory is
// not cleared (no clearing pass, entries are written before being read).
// ----------------------------------------------------------------------------
// sparse_table_range_min_max_core
// Sparse-table engine giving range maximum of upper values and range minimum
// of lower values over loaded pairs, held in one dual-read table memory.
// ----------------------------------------------------------------------------
module sparse_table_range_min_max_core #(
   parameter int MAX_ELEMENTS = strmm_pkg::DEF_MAX_ELEMENTS,
   parameter int LEVELS       = strmm_pkg::DEF_LEVELS
) (
   input  logic         clock,
   input  logic         reset,
   strmm_chan_if.sink   req_chan,
   strmm_chan_if.source rsp_chan
);
   import strmm_pkg::*;

   localparam int IW    = $clog2(MAX_ELEMENTS);
   localparam int CW    = $clog2(MAX_ELEMENTS + 1);
   localparam int LW    = $clog2(LEVELS);
   localparam int LCW   = $clog2(LEVELS + 1);
   localparam int AW    = LW + IW;
   localparam int DEPTH = LEVELS * (2 ** IW);
   localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
   localparam int XW1   = XW + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LEVEL = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   // control registers
   logic [1:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           built_ff, built_in;
   logic [LCW-1:0] lvl_ff, lvl_in;
   logic [CW-1:0]  half_ff, half_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           wb_valid_ff, wb_valid_in;
   logic [AW-1:0]  wb_addr_ff, wb_addr_in;
   logic           s1_valid_ff, s1_valid_in;
   logic [1:0]     s1_status_ff, s1_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // table memory and its registered read ports
   pair_type      pair_mem_ff [DEPTH];
   pair_type      rd_a_ff, rd_b_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pair_type      wr_data;

   // request decode
   logic           req_accept, out_free;
   logic           is_load, is_build, is_query;
   logic [XW-1:0]  left_x, right_x;
   logic [LEN_W-1:0] len;
   logic [LOG_W-1:0] k_raw;
   logic [LW-1:0]  q_lvl;
   logic [XW1-1:0] q_pow, q_idx_x;
   logic           bad_range;
   logic [CW:0]    span;
   pair_type       merged;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!s1_valid_ff || out_free);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign span = {half_ff, 1'b0};

   // mode decode
   always_comb begin
      is_load  = 1'b0;
      is_build = 1'b0;
      is_query = 1'b0;
      unique case (req_chan.payload.mode)
         MODE_LOAD:  is_load  = 1'b1;
         MODE_BUILD: is_build = 1'b1;
         MODE_QUERY: is_query = 1'b1;
         default: ;
      endcase
   end

   // query level and lookup indices
   always_comb begin
      left_x  = XW'(req_chan.payload.range_left);
      right_x = XW'(req_chan.payload.range_right);
      len = {1'b0, req_chan.payload.range_right} - {1'b0, req_chan.payload.range_left}
            + LEN_W'(1);
      k_raw = '0;
      for (int b = 0; b < LEN_W; b++) begin
         if (len[b]) k_raw = LOG_W'(b);
      end
      if (int'(k_raw) > LEVELS - 1) q_lvl = LW'(LEVELS - 1);
      else q_lvl = LW'(k_raw);
      q_pow   = XW1'(1) << q_lvl;
      q_idx_x = XW1'(right_x) + XW1'(1) - q_pow;
      bad_range = (left_x > right_x) || (right_x >= XW'(count_ff));
   end

   // combine the two lookups
   always_comb begin
      merged.upper = (rd_a_ff.upper > rd_b_ff.upper) ? rd_a_ff.upper : rd_b_ff.upper;
      merged.lower = (rd_a_ff.lower < rd_b_ff.lower) ? rd_a_ff.lower : rd_b_ff.lower;
   end

   // sequencer, memory port selection and result pipeline
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      built_in     = built_ff;
      lvl_in       = lvl_ff;
      half_in      = half_ff;
      idx_in       = idx_ff;
      wb_valid_in  = 1'b0;
      wb_addr_in   = wb_addr_ff;
      s1_valid_in  = s1_valid_ff;
      s1_status_in = s1_status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr_a    = {q_lvl, IW'(left_x)};
      rd_addr_b    = {q_lvl, IW'(q_idx_x)};
      wr_en        = wb_valid_ff;
      wr_addr      = wb_addr_ff;
      wr_data      = merged;

      // result register
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
         rsp_data_in.status = s1_status_ff;
         if (s1_status_ff == STAT_OK) begin
            rsp_data_in.range_max = merged.upper;
            rsp_data_in.range_min = merged.lower;
         end else begin
            rsp_data_in.range_max = '0;
            rsp_data_in.range_min = '0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_load && (count_ff < CW'(MAX_ELEMENTS))) begin
               wr_en    = 1'b1;
               wr_addr  = {LW'(0), count_ff[IW-1:0]};
               wr_data.upper = req_chan.payload.upper_value;
               wr_data.lower = req_chan.payload.lower_value;
               count_in = count_ff + CW'(1);
               built_in = 1'b0;
            end
            if (req_accept && is_build) begin
               lvl_in   = LCW'(1);
               half_in  = CW'(1);
               state_in = ST_LEVEL;
            end
            if (req_accept && is_query) begin
               rd_en       = 1'b1;
               s1_valid_in = 1'b1;
               if (!built_ff) s1_status_in = STAT_NOT_BUILT;
               else if (bad_range) s1_status_in = STAT_BAD_RANGE;
               else s1_status_in = STAT_OK;
            end
         end
         ST_LEVEL: begin
            // also the gap that lets the previous level's last write land
            if ((int'(lvl_ff) < LEVELS) && (span <= (CW + 1)'(count_ff))) begin
               idx_in   = '0;
               state_in = ST_READ;
            end else begin
               built_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en       = 1'b1;
            rd_addr_a   = {LW'(lvl_ff - LCW'(1)), idx_ff};
            rd_addr_b   = {LW'(lvl_ff - LCW'(1)), IW'((CW + 1)'(idx_ff) + (CW + 1)'(half_ff))};
            wb_valid_in = 1'b1;
            wb_addr_in  = {lvl_ff[LW-1:0], idx_ff};
            if (((CW + 1)'(idx_ff) + span) == (CW + 1)'(count_ff)) begin
               lvl_in   = lvl_ff + LCW'(1);
               half_in  = CW'(span);
               state_in = ST_LEVEL;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         built_ff     <= 1'b0;
         wb_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         built_ff     <= built_in;
         wb_valid_ff  <= wb_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      half_ff      <= half_in;
      idx_ff       <= idx_in;
      wb_addr_ff   <= wb_addr_in;
      s1_status_ff <= s1_status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // table memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) pair_mem_ff[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_a_ff <= pair_mem_ff[rd_addr_a];
         rd_b_ff <= pair_mem_ff[rd_addr_b];
      end
   end

endmodule

// ===== hw/rtl/strmm_checker.sv =====
// ----------------------------------------------------------------------------
// strmm_checker
// Port-level checks of the range max / min engine, bound to the engine core.
// ----------------------------------------------------------------------------
module strmm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [1:0]                  req_mode,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [strmm_pkg::VAL_W-1:0] rsp_max,
   input logic [strmm_pkg::VAL_W-1:0] rsp_min,
   input logic [1:0]                  rsp_status
);
   import strmm_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max) && $stable(rsp_min)
      && $stable(rsp_status))
      else $error("stalled result changed");

   // error results carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_max == '0 && rsp_min == '0)
      else $error("error result with non-zero data");

   // a fresh result follows a query transaction through the read / status stage and the result register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_mode == MODE_QUERY, 2))
      else $error("result without a query");

   // a build holds off requests while the table is filled
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_BUILD |=> !req_ready)
      else $error("request taken during build");

endmodule

bind sparse_table_range_min_max_core strmm_checker u_strmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_mode   (req_chan.payload.mode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_max    (rsp_chan.payload.range_max),
   .rsp_min    (rsp_chan.payload.range_min),
   .rsp_status (rsp_chan.payload.status)
);
